/* sv/adll_pkg.sv */
`timescale 1ns / 1ps

package adll_pkg;

	// Field widths of the stream payloads
	localparam int OPCODE_W = 3;
	localparam int FIELD_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 24;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam opcode_t OP_PUSH_BACK     = 3'd0;
	localparam opcode_t OP_PUSH_FRONT    = 3'd1;
	localparam opcode_t OP_POP_BACK      = 3'd2;
	localparam opcode_t OP_POP_FRONT     = 3'd3;
	localparam opcode_t OP_INSERT_AFTER  = 3'd4;
	localparam opcode_t OP_INSERT_BEFORE = 3'd5;
	localparam opcode_t OP_ERASE         = 3'd6;

	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_BAD_INSERT = 3'd1;
	localparam status_t ST_FULL       = 3'd2;
	localparam status_t ST_EMPTY      = 3'd3;
	localparam status_t ST_BAD_ERASE  = 3'd4;
	localparam status_t ST_ERASE_END  = 3'd5;

	// Controller to datapath
	typedef struct packed {
		logic load;   // capture beat, issue link reads
		logic exec;   // decide, first write set, load result
		logic finish; // second write set
	} adll_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_room; // result register free or draining this cycle
	} adll_sts_t;

endpackage

/* sv/array_doubly_linked_list_top.sv */
`timescale 1ns / 1ps

// Doubly linked list kept in SLOTS fixed slots, slot 0 being the null link.
// Each input beat carries one opcode (push back/front, pop back/front,
// insert after/before a slot, erase a slot) and returns one result beat with
// a status, the slot allocated or freed (0 on error) and the head and tail
// after the operation. An item goes through the registered link reads, a
// step to decide and apply the first set of link writes, and a step for the
// second set, since the next and prev link memories each have a single
// write port and an operation touches up to two entries of each; the next
// item is accepted only once the second set is done. The result beat sits
// in an output register; while it is held, the following item is accepted
// and waits after its reads until the register frees. No clearing pass is
// run after reset: slots never touched are tracked by a high-water mark and
// read back as their reset links, so the block is ready at once.
module array_doubly_linked_list_top #(
	parameter int SLOTS      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata: opcode [2:0], slot_index [8:3], value [40:9], zero [47:41]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [adll_pkg::S_TDATA_W-1:0]    s_tdata,
	// m_tdata: status [2:0], used_slot [8:3], head_slot [14:9],
	//          tail_slot [20:15], zero [23:21]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [adll_pkg::M_TDATA_W-1:0]    m_tdata
);
	import adll_pkg::*;

	adll_cmd_t cmd;
	adll_sts_t sts;

	// Unpack the input beat
	opcode_t              opcode;
	logic [FIELD_W-1:0]   slot_index;
	logic [VALUE_W-1:0]   value;

	assign opcode     = s_tdata[2:0];
	assign slot_index = s_tdata[8:3];
	assign value      = s_tdata[40:9];

	status_t            status;
	logic [FIELD_W-1:0] used_slot, head_slot, tail_slot;

	// Sequence each item: accept, execute, finish
	adll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Link memories, list pointers and the result register
	adll_datapath #(
		.SLOTS      (SLOTS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.slot_index (slot_index),
		.value      (value),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (status),
		.out_used   (used_slot),
		.out_head   (head_slot),
		.out_tail   (tail_slot)
	);

	// Pack the result beat, pad to whole bytes
	assign m_tdata = {3'b000, tail_slot, head_slot, used_slot, status};

endmodule

/* sv/adll_ctrl.sv */
`timescale 1ns / 1ps

module adll_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  adll_pkg::adll_sts_t sts,
	output adll_pkg::adll_cmd_t cmd
);
	import adll_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the result register can take a new beat
				if (sts.out_room) begin
					cmd.exec = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/adll_datapath.sv */
`timescale 1ns / 1ps

module adll_datapath #(
	parameter int SLOTS      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  adll_pkg::adll_cmd_t             cmd,
	output adll_pkg::adll_sts_t             sts,
	input  adll_pkg::opcode_t               opcode,
	input  logic [adll_pkg::FIELD_W-1:0]    slot_index,
	input  logic [adll_pkg::VALUE_W-1:0]    value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output adll_pkg::status_t               out_status,
	output logic [adll_pkg::FIELD_W-1:0]    out_used,
	output logic [adll_pkg::FIELD_W-1:0]    out_head,
	output logic [adll_pkg::FIELD_W-1:0]    out_tail
);
	import adll_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = (AW + 1 > FIELD_W) ? AW + 1 : FIELD_W;
	localparam logic [AW:0]   SLOTS_A = (AW + 1)'(SLOTS);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	typedef logic [AW-1:0] ptr_t;

	typedef struct packed {
		logic en;
		ptr_t addr;
		ptr_t data;
	} lwr_t;

	function automatic logic [FIELD_W-1:0] to_fld(input ptr_t p);
		logic [CW-1:0] e;
		e = CW'(p);
		return e[FIELD_W-1:0];
	endfunction

	// Slot memories
	ptr_t                  nxt_mem  [SLOTS];
	ptr_t                  prv_mem  [SLOTS];
	logic                  use_mem  [SLOTS];
	logic [DATA_WIDTH-1:0] elem_mem [SLOTS];

	// List registers; slots at or above fresh_q were never touched
	ptr_t    head_q, tail_q, free_q;
	logic [AW:0] fresh_q;

	opcode_t              op_q;
	logic [FIELD_W-1:0]   idx_q;
	logic [VALUE_W-1:0]   val_q;

	ptr_t nxt_a_q, nxt_f_q, prv_q;
	logic use_q;

	lwr_t n2_q, p2_q;

	logic    out_valid_q;
	status_t out_status_q;
	logic [FIELD_W-1:0] out_used_q, out_head_q, out_tail_q;

	// Read addresses at the accepting edge
	logic [CW-1:0] in_idx_c;
	ptr_t in_addr, rd_a_addr, rd_p_addr;

	assign in_idx_c  = CW'(slot_index);
	assign in_addr   = in_idx_c[AW-1:0];
	assign rd_a_addr = (opcode == OP_POP_FRONT) ? head_q : in_addr;
	assign rd_p_addr = (opcode == OP_POP_BACK)  ? tail_q : in_addr;

	// Decision
	logic [CW-1:0] idx_c;
	ptr_t          idx_a;
	logic [AW:0]   free_inc;
	logic          free_fresh;
	ptr_t          nf;
	logic          idx_ok;

	status_t st;
	ptr_t    used, head_d, tail_d, free_d;
	logic [AW:0] fresh_d;
	logic    take;
	lwr_t    n1, n2, p1, p2;
	logic    use_we, use_wd;
	ptr_t    use_wa;

	assign idx_c      = CW'(idx_q);
	assign idx_a      = idx_c[AW-1:0];
	assign free_inc   = {1'b0, free_q} + 1'b1;
	assign free_fresh = ({1'b0, free_q} >= fresh_q);
	assign nf         = free_fresh ? ((free_inc < SLOTS_A) ? free_inc[AW-1:0] : '0) : nxt_f_q;
	assign idx_ok     = (idx_c != '0) && (idx_c < SLOTS_C) && (idx_c < CW'(fresh_q)) && use_q;

	always_comb begin
		st      = ST_OK;
		used    = '0;
		head_d  = head_q;
		tail_d  = tail_q;
		free_d  = free_q;
		fresh_d = fresh_q;
		take    = 1'b0;
		n1      = '0;
		n2      = '0;
		p1      = '0;
		p2      = '0;
		use_we  = 1'b0;
		use_wa  = '0;
		use_wd  = 1'b0;
		case (op_q) inside
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (free_q == '0) begin
					st = ST_FULL;
				end else begin
					take = 1'b1;
					used = free_q;
					if (head_q == '0) begin
						n1 = '{1'b1, free_q, '0};
						p1 = '{1'b1, free_q, '0};
						head_d = free_q;
						tail_d = free_q;
					end else if (op_q == OP_PUSH_BACK) begin
						n1 = '{1'b1, free_q, '0};
						n2 = '{1'b1, tail_q, free_q};
						p1 = '{1'b1, free_q, tail_q};
						tail_d = free_q;
					end else begin
						n1 = '{1'b1, free_q, head_q};
						p1 = '{1'b1, free_q, '0};
						p2 = '{1'b1, head_q, free_q};
						head_d = free_q;
					end
				end
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (head_q == '0 || tail_q == '0) begin
					st = ST_EMPTY;
				end else if (op_q == OP_POP_BACK) begin
					used   = tail_q;
					tail_d = prv_q;
					if (prv_q == '0) begin
						head_d = '0;
					end else begin
						n2 = '{1'b1, prv_q, '0};
					end
					n1 = '{1'b1, tail_q, free_q};
					p1 = '{1'b1, tail_q, '0};
					use_we = 1'b1;
					use_wa = tail_q;
					free_d = tail_q;
				end else begin
					used   = head_q;
					head_d = nxt_a_q;
					if (nxt_a_q == '0) begin
						tail_d = '0;
					end else begin
						p2 = '{1'b1, nxt_a_q, '0};
					end
					n1 = '{1'b1, head_q, free_q};
					p1 = '{1'b1, head_q, '0};
					use_we = 1'b1;
					use_wa = head_q;
					free_d = head_q;
				end
			end
			OP_INSERT_AFTER, OP_INSERT_BEFORE: begin
				if (!idx_ok || (op_q == OP_INSERT_AFTER && nxt_a_q == '0) ||
				    (op_q == OP_INSERT_BEFORE && prv_q == '0)) begin
					st = ST_BAD_INSERT;
				end else if (free_q == '0) begin
					st = ST_FULL;
				end else begin
					take = 1'b1;
					used = free_q;
					if (op_q == OP_INSERT_AFTER) begin
						n1 = '{1'b1, idx_a, free_q};
						n2 = '{1'b1, free_q, nxt_a_q};
						p1 = '{1'b1, nxt_a_q, free_q};
						p2 = '{1'b1, free_q, idx_a};
					end else begin
						p1 = '{1'b1, idx_a, free_q};
						p2 = '{1'b1, free_q, prv_q};
						n1 = '{1'b1, prv_q, free_q};
						n2 = '{1'b1, free_q, idx_a};
					end
				end
			end
			OP_ERASE: begin
				if (!idx_ok) begin
					st = ST_BAD_ERASE;
				end else if (prv_q == '0 || nxt_a_q == '0) begin
					st = ST_ERASE_END;
				end else begin
					used = idx_a;
					n1 = '{1'b1, prv_q, nxt_a_q};
					p1 = '{1'b1, nxt_a_q, prv_q};
					n2 = '{1'b1, idx_a, free_q};
					p2 = '{1'b1, idx_a, '0};
					use_we = 1'b1;
					use_wa = idx_a;
					free_d = idx_a;
				end
			end
			default: ;
		endcase
		if (take) begin
			free_d = nf;
			use_we = 1'b1;
			use_wa = free_q;
			use_wd = 1'b1;
			if (free_fresh) begin
				fresh_d = fresh_q + 1'b1;
			end
		end
	end

	// Link write ports: first set on exec, deferred set on finish
	lwr_t nxt_w, prv_w;

	always_comb begin
		nxt_w = '0;
		prv_w = '0;
		if (cmd.exec) begin
			nxt_w = n1;
			prv_w = p1;
		end else if (cmd.finish) begin
			nxt_w = n2_q;
			prv_w = p2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nxt_a_q <= nxt_mem[rd_a_addr];
			nxt_f_q <= nxt_mem[free_q];
			prv_q   <= prv_mem[rd_p_addr];
			use_q   <= use_mem[in_addr];
		end
		if (nxt_w.en) begin
			nxt_mem[nxt_w.addr] <= nxt_w.data;
		end
		if (prv_w.en) begin
			prv_mem[prv_w.addr] <= prv_w.data;
		end
		if (cmd.exec && use_we) begin
			use_mem[use_wa] <= use_wd;
		end
		if (cmd.exec && take) begin
			elem_mem[free_q] <= DATA_WIDTH'(val_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			idx_q <= slot_index;
			val_q <= value;
		end
		if (cmd.exec) begin
			out_status_q <= st;
			out_used_q   <= to_fld(used);
			out_head_q   <= to_fld(head_d);
			out_tail_q   <= to_fld(tail_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			free_q      <= ptr_t'(1);
			fresh_q     <= (AW + 1)'(1);
			n2_q        <= '0;
			p2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				free_q  <= free_d;
				fresh_q <= fresh_d;
				n2_q    <= n2;
				p2_q    <= p2;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_room = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_status   = out_status_q;
	assign out_used     = out_used_q;
	assign out_head     = out_head_q;
	assign out_tail     = out_tail_q;

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == '0) == (tail_q == '0))
		else $error("head and tail disagree on an empty list");

	a_free_not_listed: assert property (@(posedge clk) disable iff (!arst_n)
		(free_q != '0) |-> (free_q != head_q && free_q != tail_q))
		else $error("free slot is also an end of the list");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= SLOTS_A)
		else $error("untouched slot mark beyond the slot count");

	a_exec_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || out_ready))
		else $error("result overwritten while still held");

	a_valid_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.exec))
		else $error("result raised without an executed item");

endmodule
